@@ sv/rse_pkg.sv @@
`timescale 1ns / 1ps
// rse_pkg: shared types and constants of the rpn stack evaluator
// token codes, status codes, state encoding; no dependencies
package rse_pkg;

    localparam int WORD_W     = 32;
    localparam int DIV_STEP_W = $clog2(WORD_W);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_END  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIVZERO   = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_DEPTH     = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ sv/rpn_stack_evaluator_unit.sv @@
`timescale 1ns / 1ps
// rpn_stack_evaluator_unit: reverse polish evaluator over pre-split tokens
// uses rse_pkg, rse_stack_mem, rse_div
//
// input channel i_valid/o_ready carries one token per item (i_op, i_digit);
// output channel o_valid/i_ready carries one result item per token.
// the top of stack is held in a register, the entries below it in a
// synchronous memory with a registered read port.
// path from accept to result: push, end, error or ignored token go to S_RESP
// and the output register; add, sub, mul pass S_READ first (one memory read
// for the left operand); divide adds S_DIV for the one-bit-per-cycle divider.
// one token is in work at a time; o_ready is high while no token is in work,
// also while a finished result still waits in the output register.
// when the receiver stalls, the finished next result waits until the
// output register is taken, then o_ready rises again.
// reset empties the stack and clears the error; no clearing pass is needed.
// end token: reports result, first error or ST_DEPTH, and empties the stack.
module rpn_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_op,
    input  logic [3:0]                        i_digit,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [2:0]                        o_status,
    output logic signed [rse_pkg::WORD_W-1:0] o_top_value,
    output logic                              o_top_valid,
    output logic                              o_final_res
);
    import rse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [2:0]        r_err, n_err;
    logic [WORD_W-1:0] r_top, n_top;
    logic [2:0]        r_op, n_op;
    logic              r_fin, n_fin;
    logic [2:0]        r_end_status, n_end_status;
    logic [WORD_W-1:0] r_end_value, n_end_value;

    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_status, n_out_status;
    logic [WORD_W-1:0] r_out_value, n_out_value;
    logic              r_out_tv, n_out_tv;
    logic              r_out_fin, n_out_fin;

    logic              in_acc;
    logic              mem_we, mem_re;
    logic [WORD_W-1:0] mem_rdata;
    logic [CW-1:0]     cnt_m1, cnt_m2;
    logic              div_start;
    t_div_stat         div_stat;
    logic [WORD_W-1:0] div_q;
    logic [WORD_W-1:0] mul_res;
    logic              live;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign cnt_m1  = r_count - 1'b1;
    assign cnt_m2  = r_count - CW'(2);
    assign mul_res = mem_rdata * r_top;
    assign live    = (r_err == ST_OK) && (r_count != '0);

    rse_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (cnt_m1[AW-1:0]),
        .i_wdata (r_top),
        .i_re    (mem_re),
        .i_raddr (cnt_m2[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    rse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mem_rdata),
        .i_divisor  (r_top),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_top        = r_top;
        n_op         = r_op;
        n_fin        = r_fin;
        n_end_status = r_end_status;
        n_end_value  = r_end_value;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_tv     = r_out_tv;
        n_out_fin    = r_out_fin;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        div_start    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_op;
                    n_fin   = 1'b0;
                    n_state = S_RESP;
                    if (i_op == OP_END) begin
                        n_fin = 1'b1;
                        if (r_err != ST_OK) begin
                            n_end_status = r_err;
                        end else if (r_count != CW'(1)) begin
                            n_end_status = ST_DEPTH;
                        end else begin
                            n_end_status = ST_OK;
                        end
                        n_end_value = (r_err == ST_OK && r_count == CW'(1)) ? r_top : '0;
                        n_count     = '0;
                        n_err       = ST_OK;
                    end else if (r_err == ST_OK) begin
                        case (i_op)
                            OP_PUSH: begin
                                if (i_digit > DIGIT_MAX) begin
                                    n_err = ST_INVALID;
                                end else if (r_count == CW'(STACK_DEPTH)) begin
                                    n_err = ST_OVERFLOW;
                                end else begin
                                    mem_we  = (r_count != '0);
                                    n_top   = {{(WORD_W - 4){1'b0}}, i_digit};
                                    n_count = r_count + 1'b1;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                if (r_count < CW'(2)) begin
                                    n_err = ST_UNDERFLOW;
                                end else begin
                                    mem_re  = 1'b1;
                                    n_state = S_READ;
                                end
                            end
                            default: begin
                                n_err = ST_INVALID;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                n_state = S_RESP;
                case (r_op)
                    OP_ADD: begin
                        n_top   = mem_rdata + r_top;
                        n_count = cnt_m1;
                    end
                    OP_SUB: begin
                        n_top   = mem_rdata - r_top;
                        n_count = cnt_m1;
                    end
                    OP_MUL: begin
                        n_top   = mul_res;
                        n_count = cnt_m1;
                    end
                    default: begin
                        if (r_top == '0) begin
                            n_err = ST_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_top   = div_q;
                    n_count = cnt_m1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_fin   = r_fin;
                    if (r_fin) begin
                        n_out_status = r_end_status;
                        n_out_value  = r_end_value;
                        n_out_tv     = (r_end_status == ST_OK);
                    end else begin
                        n_out_status = r_err;
                        n_out_value  = live ? r_top : '0;
                        n_out_tv     = live;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
        r_top        <= n_top;
        r_op         <= n_op;
        r_end_status <= n_end_status;
        r_end_value  <= n_end_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_tv     <= n_out_tv;
        r_out_fin    <= n_out_fin;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_top_value = r_out_value;
    assign o_top_valid = r_out_tv;
    assign o_final_res = r_out_fin;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_top_valid) |-> (o_status == ST_OK))
        else $error("top valid with error status");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_op == OP_END) |=> (r_count == '0 && r_err == ST_OK))
        else $error("end item did not clear the stack");

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("second item taken while one is in work");

endmodule

@@ sv/rse_stack_mem.sv @@
`timescale 1ns / 1ps
// rse_stack_mem: operand storage below the top of stack
// one write port, one registered read port; uses rse_pkg
module rse_stack_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [rse_pkg::WORD_W-1:0]    i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [rse_pkg::WORD_W-1:0]    o_rdata
);
    import rse_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rse_div.sv @@
`timescale 1ns / 1ps
// rse_div: signed divider, truncating toward zero, one quotient bit per cycle
// restoring division on magnitudes; uses rse_pkg
module rse_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rse_pkg::WORD_W-1:0]    i_dividend,
    input  logic [rse_pkg::WORD_W-1:0]    i_divisor,
    output rse_pkg::t_div_stat            o_stat,
    output logic [rse_pkg::WORD_W-1:0]    o_quotient
);
    import rse_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_STEP_W-1:0] r_step, n_step;
    logic [WORD_W-1:0]     r_rem, n_rem;
    logic [WORD_W-1:0]     r_quo, n_quo;
    logic [WORD_W-1:0]     r_den, n_den;
    logic                  r_neg, n_neg;
    logic [WORD_W:0]       shifted;
    logic [WORD_W:0]       diff;
    logic                  fits;

    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign fits    = !diff[WORD_W];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_quo  = i_dividend[WORD_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_den  = i_divisor[WORD_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_neg  = i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            n_rem  = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            n_quo  = {r_quo[WORD_W-2:0], fits};
            n_step = r_step + 1'b1;
            if (r_step == DIV_STEP_W'(WORD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_neg  <= n_neg;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule
